@@ rtl/assert_macros.svh @@
// Assertion macros shared by the key index six-bit packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge out of reset.
`define KISBP_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Antecedent in a cycle implies consequent in the same cycle.
`define KISBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent in a cycle implies consequent in the next cycle.
`define KISBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define KISBP_ASSERT(lbl, clk, rst_n, expr)
`define KISBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KISBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/kisbp_pkg.sv @@
// Shared constants and types of the key index six-bit packer.
package kisbp_pkg;

  localparam int KEY_DEPTH   = 64;
  localparam int KEY_AW      = $clog2(KEY_DEPTH);
  localparam int CODE_W      = 6;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 6;
  localparam int BUF_W       = 24;

  localparam logic [CODE_W-1:0] END_CODE       = 6'd63;
  localparam logic [LEN_W-1:0]  KEY_LENGTH_RST = 6'd63;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // search unit -> sequencer
  typedef struct packed {
    logic              done;
    logic              miss;
    logic [CODE_W-1:0] code;
  } srch_res_t;

  // sequencer -> packer
  typedef struct packed {
    logic              go;
    logic              last;
    logic              miss;
    logic [CODE_W-1:0] code;
  } pack_cmd_t;

endpackage

@@ rtl/kisbp_key_search.sv @@
// Key table memory and the iterative first-match search unit.
`include "assert_macros.svh"

module kisbp_key_search
  import kisbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [LEN_W-1:0]  wr_slot,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              start,
  input  logic [CHAR_W-1:0] ch,
  input  logic [LEN_W-1:0]  key_length,
  output srch_res_t         res
);

  logic [CHAR_W-1:0] mem [KEY_DEPTH];
  logic [CHAR_W-1:0] rd_data_r;
  logic [KEY_AW-1:0] rd_addr;
  logic [KEY_AW:0]   idx_r, idx_nxt;
  logic [KEY_AW:0]   limit;
  logic [CHAR_W-1:0] ch_r;
  logic              busy_r, busy_nxt;
  logic              at_end;

  // search never runs past the table
  assign limit  = (32'(key_length) > KEY_DEPTH) ? (KEY_AW + 1)'(KEY_DEPTH)
                                                : (KEY_AW + 1)'(key_length);
  assign at_end = (idx_r >= limit);

  // rd_data_r holds entry idx_r; fetch the following one meanwhile
  assign rd_addr = busy_r ? KEY_AW'(idx_r + 1'b1) : '0;

  assign res.done = busy_r && (at_end || (rd_data_r == ch_r));
  assign res.miss = at_end;
  assign res.code = at_end ? '0 : CODE_W'(idx_r);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (res.done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    if (start) ch_r <= ch;
  end

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_slot) < KEY_DEPTH)) mem[KEY_AW'(wr_slot)] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  `KISBP_ASSERT(a_start_when_free, clk, rst_n, !(start && busy_r))
  `KISBP_ASSERT_IMP(a_hit_below_length, clk, rst_n, res.done && !res.miss,
                    32'(res.code) < 32'(key_length))

endmodule

@@ rtl/kisbp_packer.sv @@
// Bit packer: merges codes into bytes and drives the output register.
`include "assert_macros.svh"

module kisbp_packer
  import kisbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pack_cmd_t   cmd,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte,
  output logic        out_lookup_miss
);

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       partial_r, partial_nxt;
  logic [BUF_W-1:0] buf_r, buf_nxt;
  logic [1:0]       rem_r, rem_nxt;
  logic             last_r, miss_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r, out_miss_r;

  logic [2:0]       pend;
  logic [4:0]       nbits;
  logic [BUF_W-1:0] merged, spill;
  logic             take;

  // pending bits before this code, (6 * phase) mod 8
  always_comb begin
    case (phase_r)
      2'd0:    pend = 3'd0;
      2'd1:    pend = 3'd6;
      2'd2:    pend = 3'd4;
      2'd3:    pend = 3'd2;
      default: pend = 3'd0;
    endcase
  end

  always_comb begin
    nbits  = 5'(pend) + 5'd6 + (cmd.last ? 5'd6 : 5'd0);
    merged = {partial_r, 16'b0}
           | ((BUF_W'(cmd.code) << (BUF_W - CODE_W)) >> pend)
           | (cmd.last ? ((BUF_W'(END_CODE) << (BUF_W - CODE_W)) >> (5'(pend) + 5'd6))
                       : '0);
    spill  = merged << {nbits[4:3], 3'b000};
  end

  assign take = !out_valid_r || !out_stall;
  assign busy = (rem_r != 2'd0);

  always_comb begin
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    buf_nxt     = buf_r;
    rem_nxt     = rem_r;
    if (cmd.go) begin
      buf_nxt = merged;
      if (cmd.last) begin
        rem_nxt     = 2'((nbits + 5'd7) >> 3);
        phase_nxt   = 2'd0;
        partial_nxt = 8'd0;
      end else begin
        rem_nxt     = nbits[4:3];
        phase_nxt   = phase_r + 2'd1;
        partial_nxt = spill[BUF_W-1 -: 8];
      end
    end else if (take && busy) begin
      buf_nxt = buf_r << 8;
      rem_nxt = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 2'd0;
      partial_r   <= 8'd0;
      rem_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      rem_r     <= rem_nxt;
      if (take) out_valid_r <= busy && !cmd.go;
    end
    buf_r <= buf_nxt;
    if (cmd.go) begin
      last_r <= cmd.last;
      miss_r <= cmd.miss;
    end
    if (take && busy && !cmd.go) begin
      out_byte_r <= buf_r[BUF_W-1 -: 8];
      out_last_r <= last_r && (rem_r == 2'd1);
      out_miss_r <= miss_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_byte   = out_last_r;
  assign out_lookup_miss = out_miss_r;

  `KISBP_ASSERT(a_go_when_drained, clk, rst_n, !(cmd.go && busy))
  `KISBP_ASSERT_NXT(a_rem_counts_down, clk, rst_n, busy, rem_r <= $past(rem_r))

endmodule

@@ rtl/key_index_six_bit_packer_top.sv @@
// Key index six-bit packer: sequencer, configuration register and submodules.
//
// Each encode request searches the loaded key table for the first entry equal
// to its character, one table entry per cycle through a single memory read
// port and comparator, then packs the 6-bit index MSB first, four codes to
// three bytes; a request marked last appends end code 63 and flushes a
// zero-padded final byte flagged by out_last_byte. A character not found in
// the first key_length entries is coded 0 with out_lookup_miss set on its
// bytes. An encode request occupies the block while its search steps through
// the entries up to i, the index of the match (key_length on a miss), and
// while it emits its b bytes (0 to 3, held longer under output stall). A
// load request writes one table entry. Table entries read before being
// loaded are undefined. cfg_key_length may be written only while the block is idle.
`include "assert_macros.svh"

module key_index_six_bit_packer_top
  import kisbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [CHAR_W-1:0] in_char_in,
  input  logic              in_is_last,
  input  logic [LEN_W-1:0]  in_key_slot,
  input  logic [CHAR_W-1:0] in_key_char,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last_byte,
  output logic              out_lookup_miss,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_key_length
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] key_length_r;
  logic             last_r;
  logic             accept;
  logic             start_search;
  logic             load_key;
  logic             pk_busy;
  srch_res_t        res;
  pack_cmd_t        cmd;

  assign in_stall     = (state_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign accept       = in_valid && !in_stall;
  assign start_search = accept && (in_operation == OP_ENCODE);
  assign load_key     = accept && (in_operation == OP_LOAD);

  assign cmd.go   = (state_r == ST_SEARCH) && res.done;
  assign cmd.last = last_r;
  assign cmd.miss = res.miss;
  assign cmd.code = res.code;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start_search) state_nxt = ST_SEARCH;
      ST_SEARCH: if (res.done) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!pk_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      key_length_r <= KEY_LENGTH_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) key_length_r <= cfg_key_length;
    end
    if (start_search) last_r <= in_is_last;
  end

  kisbp_key_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (load_key),
    .wr_slot    (in_key_slot),
    .wr_data    (in_key_char),
    .start      (start_search),
    .ch         (in_char_in),
    .key_length (key_length_r),
    .res        (res)
  );

  kisbp_packer u_packer (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .busy            (pk_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_byte   (out_last_byte),
    .out_lookup_miss (out_lookup_miss)
  );

  `KISBP_ASSERT_NXT(a_search_to_drain, clk, rst_n, cmd.go, state_r == ST_DRAIN)

endmodule

@@ test/packed_byte_checker.sv @@
// Checker for the key index six-bit packer: predicts packed bytes and compares results.
module packed_byte_checker
  import kisbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_operation,
  input  logic [CHAR_W-1:0] in_char_in,
  input  logic              in_is_last,
  input  logic [LEN_W-1:0]  in_key_slot,
  input  logic [CHAR_W-1:0] in_key_char,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_byte,
  input  logic              out_last_byte,
  input  logic              out_lookup_miss,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_key_length,
  output int                mismatch_count,
  output int                bytes_pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       miss;
  } packed_byte_t;

  packed_byte_t      expected_bytes[$];
  packed_byte_t      oldest;
  logic [CHAR_W-1:0] key_copy [KEY_DEPTH];
  logic [LEN_W-1:0]  search_len;
  logic [1:0]        group_phase;
  logic [7:0]        held_bits;
  int                errors;

  initial errors = 0;

  // First-match search, then MSB-first packing of the code (and end code on last).
  task automatic predict_encode(input logic [CHAR_W-1:0] ch, input logic is_last);
    logic [31:0]       acc;
    int                pend;
    int                nbits;
    int                i;
    logic              miss;
    logic [CODE_W-1:0] code;
    packed_byte_t      pb;
    pend = (6 * int'(group_phase)) % 8;
    acc = (pend == 0) ? 32'd0 : 32'(held_bits >> (8 - pend));
    miss = 1'b1;
    code = '0;
    for (i = 0; i < int'(search_len) && i < KEY_DEPTH; i++) begin
      if (miss && key_copy[i] == ch) begin
        miss = 1'b0;
        code = CODE_W'(i);
      end
    end
    acc = (acc << CODE_W) | 32'(code);
    nbits = pend + CODE_W;
    if (is_last) begin
      acc = (acc << CODE_W) | 32'(END_CODE);
      nbits += CODE_W;
    end
    while (nbits >= 8) begin
      nbits -= 8;
      pb.data = 8'(acc >> nbits);
      pb.last = 1'b0;
      pb.miss = miss;
      expected_bytes.push_back(pb);
    end
    if (is_last) begin
      if (nbits > 0) begin
        pb.data = 8'(acc << (8 - nbits));
        pb.last = 1'b0;
        pb.miss = miss;
        expected_bytes.push_back(pb);
      end
      // flag the final byte of the message
      pb = expected_bytes.pop_back();
      pb.last = 1'b1;
      expected_bytes.push_back(pb);
      group_phase = '0;
      held_bits = '0;
    end else begin
      held_bits = (nbits == 0) ? 8'd0 : 8'(acc << (8 - nbits));
      group_phase = group_phase + 2'd1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_bytes.delete();
      search_len = KEY_LENGTH_RST;
      group_phase = '0;
      held_bits = '0;
    end else begin
      if (cfg_valid && cfg_ready) search_len = cfg_key_length;
      if (in_valid && !in_stall) begin
        if (in_operation == OP_LOAD) key_copy[in_key_slot] = in_key_char;
        else predict_encode(in_char_in, in_is_last);
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected byte %02h last %b miss %b", $time,
                     out_byte, out_last_byte, out_lookup_miss);
        end else begin
          oldest = expected_bytes.pop_front();
          if (oldest.data !== out_byte || oldest.last !== out_last_byte ||
              oldest.miss !== out_lookup_miss) begin
            errors++;
            if (errors <= 10)
              $display("%0t: byte mismatch: expected %02h last %b miss %b, got %02h last %b miss %b",
                       $time, oldest.data, oldest.last, oldest.miss,
                       out_byte, out_last_byte, out_lookup_miss);
          end
        end
      end
    end
    mismatch_count <= errors;
    bytes_pending <= expected_bytes.size();
  end

endmodule

@@ test/testbench.sv @@
// Top of the key index six-bit packer testbench: clock, reset, stimulus and verdict.
module testbench;
  import kisbp_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_GAP       = 8;
  localparam int PHASE_ITEMS   = 15;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_operation;
  logic [CHAR_W-1:0] in_char_in;
  logic              in_is_last;
  logic [LEN_W-1:0]  in_key_slot;
  logic [CHAR_W-1:0] in_key_char;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_byte;
  logic              out_last_byte;
  logic              out_lookup_miss;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_key_length;
  int                mismatch_count;
  int                bytes_pending;

  int                tx_gap_max = MAX_GAP;
  int                rx_gap_max = MAX_GAP;
  logic [CHAR_W-1:0] key_shadow [KEY_DEPTH];
  logic [LEN_W-1:0]  key_len_now;

  key_index_six_bit_packer_top dut (.*);

  packed_byte_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall before each byte.
  initial begin : byte_sink
    int hold;
    out_stall <= 1'b0;
    forever begin
      hold = $urandom_range(0, rx_gap_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(input logic op, input logic [CHAR_W-1:0] ch,
                              input logic last, input logic [LEN_W-1:0] slot,
                              input logic [CHAR_W-1:0] kch);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_char_in   <= ch;
    in_is_last   <= last;
    in_key_slot  <= slot;
    in_key_char  <= kch;
    do @(posedge clk); while (in_stall);
  endtask

  // Unused fields carry random values.
  task automatic encode_char(input logic [CHAR_W-1:0] ch, input logic last);
    send_request(OP_ENCODE, ch, last, LEN_W'($urandom), CHAR_W'($urandom));
  endtask

  task automatic load_key(input logic [LEN_W-1:0] slot, input logic [CHAR_W-1:0] kch);
    key_shadow[slot] = kch;
    send_request(OP_LOAD, CHAR_W'($urandom), 1'($urandom), slot, kch);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
  endtask

  // An encode that emits no byte may still be searching, so settle before writing.
  task automatic set_key_length(input logic [LEN_W-1:0] len);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_key_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_len_now = len;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char(input bit hit);
    if (hit && key_len_now != 0) return key_shadow[$urandom_range(0, key_len_now - 1)];
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Mostly closed messages; some left open so packing carries into the next one.
  task automatic send_message(input int n_chars);
    int k;
    bit close;
    close = $urandom_range(0, 9) != 0;
    for (k = 0; k < n_chars; k++) begin
      if ($urandom_range(0, 9) == 0) load_key(LEN_W'($urandom), CHAR_W'($urandom));
      encode_char(pick_char($urandom_range(0, 99) < 85), close && k == n_chars - 1);
    end
  endtask

  initial begin : stimulus
    int n;
    int c;
    int p;
    int sent;
    bit found;
    logic [CHAR_W-1:0] absent;
    logic [LEN_W-1:0]  phase_len [6];

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_operation   <= OP_ENCODE;
    in_char_in     <= '0;
    in_is_last     <= 1'b0;
    in_key_slot    <= '0;
    in_key_char    <= '0;
    cfg_valid      <= 1'b0;
    cfg_key_length <= KEY_LENGTH_RST;
    key_len_now = KEY_LENGTH_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // fill every slot first, so no search touches an unloaded entry
    for (n = 0; n < KEY_DEPTH; n++) load_key(LEN_W'(n), CHAR_W'($urandom));
    load_key(6'd0, 8'h00);
    load_key(6'd62, 8'hFF);
    load_key(6'd10, 8'h41);
    load_key(6'd30, 8'h41);
    load_key(6'd63, 8'h5A);

    absent = '0;
    found = 1'b1;
    for (c = 0; c < 256 && found; c++) begin
      found = 1'b0;
      for (n = 0; n < KEY_DEPTH - 1; n++)
        if (key_shadow[n] == CHAR_W'(c)) found = 1'b1;
      if (!found) absent = CHAR_W'(c);
    end

    // directed: last at each group phase, duplicate entry, misses, load mid-message
    set_key_length(6'd63);
    encode_char(8'h00, 1'b1);
    encode_char(8'hFF, 1'b0);
    encode_char(8'h41, 1'b1);
    encode_char(absent, 1'b0);
    encode_char(8'h00, 1'b0);
    encode_char(absent, 1'b1);
    encode_char(8'hFF, 1'b0);
    load_key(6'd20, key_shadow[20]);
    encode_char(8'h41, 1'b0);
    encode_char(8'h00, 1'b0);
    encode_char(8'hFF, 1'b1);
    for (n = 0; n < 5; n++) encode_char(key_shadow[n * 12], n == 4);
    set_key_length(6'd1);
    encode_char(8'h00, 1'b0);
    encode_char(8'hFF, 1'b1);
    set_key_length(6'd0);
    encode_char(8'h00, 1'b1);

    phase_len[0] = 6'd63;
    phase_len[1] = LEN_W'($urandom_range(2, 62));
    phase_len[2] = 6'd1;
    phase_len[3] = 6'd32;
    phase_len[4] = LEN_W'($urandom_range(1, 63));
    phase_len[5] = 6'd63;
    for (p = 0; p < 6; p++) begin
      set_key_length(phase_len[p]);
      tx_gap_max = (p == 2 || p == 4) ? 0 : MAX_GAP;
      rx_gap_max = (p == 2) ? 0 : MAX_GAP;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = $urandom_range(1, 9);
        send_message(n);
        sent += n;
        if (p == 3 && sent >= PHASE_ITEMS / 2 && sent - n < PHASE_ITEMS / 2)
          wait_results_drained();
      end
    end
    tx_gap_max = MAX_GAP;
    rx_gap_max = MAX_GAP;

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && bytes_pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Ends the run when no request moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
